/* sv/spmf_pkg.sv */
// Shared codes, field widths and stream packing constants for the priority FIFO.
package spmf_pkg;

    // Fixed field widths of the stream items
    localparam int LEVEL_W    = 2;
    localparam int PAYLOAD_W  = 32;
    localparam int LCOUNT_W   = 5;
    localparam int TCOUNT_W   = 7;

    // Input tdata: level [1:0], payload [33:2], zero fill to 40 bits
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    // Output tdata: out_payload [31:0], out_level [33:32],
    // level_count [38:34], total_count [45:39], zero fill to 48 bits
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

/* sv/strict_priority_multi_fifo.sv */
// Strict-priority multi-level FIFO: LEVELS ring queues, level 0 served first.
// Latency: the result of a transaction is valid the cycle after it is accepted.
// Throughput: one transaction per cycle while the output is not stalled; one output register, payload read from
//   the storage port in the accept cycle.
// Reset: synchronous, active low; clears head, tail and fill counts of every level.
//   Payload storage is not cleared; it is only read after being written.
module strict_priority_multi_fifo #(
    parameter int DEPTH      = 16,
    parameter int LEVELS     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // level [1:0], payload [33:2]
    input  logic [spmf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // func [0]
    input  logic [spmf_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_payload [31:0], out_level [33:32], level_count [38:34], total_count [45:39]
    output logic [spmf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [spmf_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser
);

    import spmf_pkg::*;

    localparam int LVL_W   = $clog2(LEVELS);
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOT_W   = $clog2(LEVELS * DEPTH + 1);
    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    // queue state
    logic [PTR_W-1:0] r_head [LEVELS];
    logic [PTR_W-1:0] r_tail [LEVELS];
    logic [CNT_W-1:0] r_fill [LEVELS];
    logic [TOT_W-1:0] r_total;
    logic [PTR_W-1:0] n_head [LEVELS];
    logic [PTR_W-1:0] n_tail [LEVELS];
    logic [CNT_W-1:0] n_fill [LEVELS];
    logic [TOT_W-1:0] n_total;

    // result register
    logic             r_out_valid;
    t_status          r_status;
    logic [LEVEL_W-1:0]  r_out_level;
    logic [LCOUNT_W-1:0] r_level_count;
    logic [TCOUNT_W-1:0] r_total_count;

    logic                  w_accept;
    t_func                 w_func;
    logic [LEVEL_W-1:0]    w_level;
    logic [PAYLOAD_W-1:0]  w_payload;
    logic                  w_lvl_ok;
    logic [LVL_W-1:0]      w_lvl_idx;
    logic [CNT_W-1:0]      w_cur_fill;
    logic                  w_found;
    logic [LVL_W-1:0]      w_sel_idx;
    t_status               w_status;
    logic [CNT_W-1:0]      w_lcount;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_func    = t_func'(i_s_axis_tuser[0]);
    assign w_level   = i_s_axis_tdata[LEVEL_W-1:0];
    assign w_payload = i_s_axis_tdata[LEVEL_W +: PAYLOAD_W];

    assign w_lvl_ok   = (int'(w_level) < LEVELS);
    assign w_lvl_idx  = LVL_W'(w_level);
    assign w_cur_fill = w_lvl_ok ? r_fill[w_lvl_idx] : '0;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // highest-priority non-empty level: scan from the lowest priority up
    always_comb begin
        w_found   = 1'b0;
        w_sel_idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_fill[i] != '0) begin
                w_found   = 1'b1;
                w_sel_idx = LVL_W'(i);
            end
        end
    end

    always_comb begin
        case (w_func)
            FUNC_ENQ: w_status = (!w_lvl_ok || w_cur_fill == CNT_W'(DEPTH)) ? ST_FULL : ST_ENQ;
            FUNC_DEQ: w_status = w_found ? ST_DEQ : ST_EMPTY;
            default:  w_status = ST_FULL;
        endcase
    end

    assign w_wr_en   = w_accept && (w_status == ST_ENQ);
    assign w_rd_en   = w_accept && (w_status == ST_DEQ);
    assign w_wr_addr = ADDR_W'(w_lvl_idx) * ADDR_W'(DEPTH) + ADDR_W'(r_tail[w_lvl_idx]);
    assign w_rd_addr = ADDR_W'(w_sel_idx) * ADDR_W'(DEPTH) + ADDR_W'(r_head[w_sel_idx]);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_total = r_total;
        if (w_wr_en) begin
            n_tail[w_lvl_idx] = ring_next(r_tail[w_lvl_idx]);
            n_fill[w_lvl_idx] = r_fill[w_lvl_idx] + 1'b1;
            n_total           = r_total + 1'b1;
        end
        if (w_rd_en) begin
            n_head[w_sel_idx] = ring_next(r_head[w_sel_idx]);
            n_fill[w_sel_idx] = r_fill[w_sel_idx] - 1'b1;
            n_total           = r_total - 1'b1;
        end
    end

    assign w_lcount = w_lvl_ok ? n_fill[w_lvl_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_fill      <= n_fill;
                r_total     <= n_total;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_status;
            r_out_level   <= (w_status == ST_DEQ) ? LEVEL_W'(w_sel_idx) : '0;
            r_level_count <= LCOUNT_W'(w_lcount);
            r_total_count <= TCOUNT_W'(n_total);
        end
    end

    spmf_mem #(
        .DATA_WIDTH (DATA_WIDTH),
        .ENTRIES    (ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (DATA_WIDTH'(w_payload)),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {
        {(OUT_TDATA_W - PAYLOAD_W - LEVEL_W - LCOUNT_W - TCOUNT_W){1'b0}},
        r_total_count,
        r_level_count,
        r_out_level,
        (r_status == ST_DEQ) ? PAYLOAD_W'(w_rd_data) : {PAYLOAD_W{1'b0}}
    };

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_total) <= ENTRIES)
        else $error("total count exceeds storage");

    a_enq_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_status == ST_ENQ |=> r_total == $past(r_total) + 1'b1)
        else $error("accepted enqueue did not raise total count");

    a_deq_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_status == ST_DEQ |=> r_total == $past(r_total) - 1'b1)
        else $error("accepted dequeue did not lower total count");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_status == ST_EMPTY |-> r_total == '0)
        else $error("empty status with entries held");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_out_valid)
        else $error("input stalled without a pending result");

endmodule

/* sv/spmf_mem.sv */
// Payload storage: one write port, one read port with registered read data.
module spmf_mem #(
    parameter int DATA_WIDTH = 32,
    parameter int ENTRIES    = 64
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0]      i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic [DATA_WIDTH-1:0]      o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [ENTRIES];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* tb/tb_strict_priority_multi_fifo.sv */
// Self-checking testbench for the strict-priority multi-level FIFO.
`timescale 1ns / 1ps

module tb_strict_priority_multi_fifo;
    import spmf_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int QLEVELS     = 4;
    localparam int RANDOM_OPS  = 400;
    localparam int HOLD_CYCLES = 400;

    // One queue result as it leaves the block
    typedef struct packed {
        t_status     st;
        logic [31:0] pay;
        logic [1:0]  lev;
        logic [4:0]  lcnt;
        logic [6:0]  tcnt;
    } t_qresult;

    typedef struct packed {
        t_func       func;
        logic [1:0]  level;
        logic [31:0] payload;
        logic [4:0]  reps;
        logic        typed;
        t_qresult    want;
    } t_stim_row;

    localparam int NUM_ROWS = 7;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        // dequeue with all levels empty
        '{FUNC_DEQ, 2'd0, 32'h0000_0000, 5'd1, 1'b1,
          '{ST_EMPTY, 32'h0000_0000, 2'd0, 5'd0, 7'd0}},
        '{FUNC_ENQ, 2'd3, 32'h0000_0000, 5'd1, 1'b1,
          '{ST_ENQ, 32'h0000_0000, 2'd0, 5'd1, 7'd1}},
        '{FUNC_ENQ, 2'd0, 32'hFFFF_FFFF, 5'd1, 1'b1,
          '{ST_ENQ, 32'h0000_0000, 2'd0, 5'd1, 7'd2}},
        // fill level 2 to the brim
        '{FUNC_ENQ, 2'd2, 32'hA500_0000, 5'd16, 1'b0,
          '{ST_ENQ, 32'h0000_0000, 2'd0, 5'd0, 7'd0}},
        // full level rejects
        '{FUNC_ENQ, 2'd2, 32'h5A5A_5A5A, 5'd1, 1'b1,
          '{ST_FULL, 32'h0000_0000, 2'd0, 5'd16, 7'd18}},
        // level 0 wins over the others; payload field is ignored
        '{FUNC_DEQ, 2'd1, 32'hDEAD_BEEF, 5'd1, 1'b1,
          '{ST_DEQ, 32'hFFFF_FFFF, 2'd0, 5'd0, 7'd17}},
        '{FUNC_DEQ, 2'd3, 32'h0000_0000, 5'd1, 1'b0,
          '{ST_ENQ, 32'h0000_0000, 2'd0, 5'd0, 7'd0}}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [IN_TDATA_W-1:0]  in_data;
    logic [IN_TUSER_W-1:0]  in_user;
    logic                   out_valid;
    logic                   out_ready;
    logic [OUT_TDATA_W-1:0] out_data;
    logic [OUT_TUSER_W-1:0] out_user;

    // predictor state
    logic [31:0] held_payload [QLEVELS][QDEPTH];
    int          rd_pos [QLEVELS];
    int          wr_pos [QLEVELS];
    int          held_cnt [QLEVELS];

    t_qresult expected_results [$];
    int       mismatches;
    logic     steady;
    logic     hold_req;

    strict_priority_multi_fifo DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_qresult queue_step(t_func f, logic [1:0] lv, logic [31:0] pl);
        t_qresult r;
        int       n;
        int       total;
        logic     found;
        r     = '{ST_EMPTY, 32'h0, 2'd0, 5'd0, 7'd0};
        found = 1'b0;
        total = 0;
        if (f == FUNC_ENQ) begin
            if (held_cnt[lv] >= QDEPTH) begin
                r.st = ST_FULL;
            end else begin
                held_payload[lv][wr_pos[lv]] = pl;
                wr_pos[lv]   = (wr_pos[lv] + 1) % QDEPTH;
                held_cnt[lv] = held_cnt[lv] + 1;
                r.st = ST_ENQ;
            end
        end else begin
            // strict priority: lowest-numbered non-empty level
            for (n = 0; n < QLEVELS; n++) begin
                if (!found && held_cnt[n] != 0) begin
                    found        = 1'b1;
                    r.st         = ST_DEQ;
                    r.pay        = held_payload[n][rd_pos[n]];
                    r.lev        = 2'(n);
                    rd_pos[n]    = (rd_pos[n] + 1) % QDEPTH;
                    held_cnt[n]  = held_cnt[n] - 1;
                end
            end
        end
        for (n = 0; n < QLEVELS; n++)
            total += held_cnt[n];
        r.lcnt = 5'(held_cnt[lv]);
        r.tcnt = 7'(total);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Offer one transaction and wait for it to be taken; valid stays high on return
    task automatic send_op(t_func f, logic [1:0] lv, logic [31:0] pl,
                           logic typed, t_qresult want);
        t_qresult pred;
        while (!steady && $urandom_range(0, 99) < 27) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= {6'b0, pl, lv};
        in_user  <= f;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        pred = queue_step(f, lv, pl);
        expected_results.push_back(typed ? want : pred);
    endtask

    // receiver: check accepted results and pick the next ready
    initial begin : result_sink
        t_qresult want;
        int       hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(out_user), 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_user[1:0] != want.st)
                        report_mismatch("status", 32'(out_user[1:0]), 32'(want.st));
                    if (out_data[31:0] != want.pay)
                        report_mismatch("out_payload", out_data[31:0], want.pay);
                    if (out_data[33:32] != want.lev)
                        report_mismatch("out_level", 32'(out_data[33:32]), 32'(want.lev));
                    if (out_data[38:34] != want.lcnt)
                        report_mismatch("level_count", 32'(out_data[38:34]), 32'(want.lcnt));
                    if (out_data[45:39] != want.tcnt)
                        report_mismatch("total_count", 32'(out_data[45:39]), 32'(want.tcnt));
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    initial begin : stimulus
        int          r;
        int          k;
        int          sent;
        int          burst;
        int          enq_pct;
        int          focus;
        logic        focused;
        t_func       f;
        logic [1:0]  lv;
        logic [31:0] pl;
        mismatches = 0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        in_user    = '0;
        i_rst_n    = 1'b0;
        for (k = 0; k < QLEVELS; k++) begin
            rd_pos[k]   = 0;
            wr_pos[k]   = 0;
            held_cnt[k] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_ROWS; r++)
            for (k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_op(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].level,
                        DIRECTED_ROWS[r].payload + 32'(k),
                        DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // random bursts that lean toward filling, mixing or draining
        sent = 0;
        while (sent < RANDOM_OPS) begin
            burst   = $urandom_range(16, 48);
            case ($urandom_range(0, 2))
                0:       enq_pct = 90;
                1:       enq_pct = 50;
                default: enq_pct = 12;
            endcase
            focus   = $urandom_range(0, QLEVELS - 1);
            focused = $urandom_range(0, 1);
            for (k = 0; k < burst && sent < RANDOM_OPS; k++) begin
                steady = (sent >= 150 && sent < 260);
                if (sent == 60)
                    hold_req = 1'b1;
                f  = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
                lv = (focused && $urandom_range(0, 3) != 0) ? 2'(focus)
                                                           : 2'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       pl = 32'h0000_0000;
                    1:       pl = 32'hFFFF_FFFF;
                    default: pl = $urandom;
                endcase
                send_op(f, lv, pl, 1'b0, '0);
                sent++;
            end
        end
        steady   = 1'b0;
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
